// ----- hdl/shpb_pkg.sv -----
// Shared types and constants for the smoothed Heaviside blend.
package shpb_pkg;

  // Default quarter-wave table depth
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;

  // Fixed point constants (Q1.16)
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  // pi in Q30, used to build the sine table
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Table entries never exceed 65536/(2*pi)
  localparam int unsigned SIN_W = 14;

  // Configuration register reset values
  localparam logic [31:0] VALUE_INSIDE_RST  = 32'd65536;
  localparam logic [31:0] VALUE_OUTSIDE_RST = 32'd0;
  localparam logic [30:0] ALPHA_RST         = 31'd65536;
  localparam logic [30:0] INV_ALPHA_RST     = 31'd65536;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_INSIDE  = 3'd0,
    REG_VALUE_OUTSIDE = 3'd1,
    REG_ALPHA         = 3'd2,
    REG_INV_ALPHA     = 3'd3
  } cfg_reg_e;

  // Where phi sits relative to the smoothing band
  typedef enum logic [1:0] {
    BAND_MID  = 2'd0,
    BAND_LOW  = 2'd1,
    BAND_HIGH = 2'd2
  } band_e;

  // Input beat
  typedef struct packed {
    logic               action;
    logic signed [31:0] level_a;
    logic signed [31:0] level_b;
  } item_t;

  // Output beat
  typedef struct packed {
    logic        [16:0] weight;
    logic signed [31:0] property_res;
  } result_t;

endpackage

// ----- hdl/smoothed_heaviside_property_blend.sv -----
// Top level: ten-stage pipeline for the sine-smoothed Heaviside property blend.
//
// Usage:
//   Input channel (item_valid / item_stall / item_data) carries one grid point
//   per beat: action selects cell mode (level_a) or side mode (average of
//   level_a and level_b). Output channel (res_valid / res_stall / res_data)
//   returns one beat per input beat with the weight and the blended property.
//   Configuration writes go over cfg_valid / cfg_ready / cfg_index / cfg_data
//   and must be issued while the pipeline is empty; cfg_ready is always high.
//   A beat passes through the ten register stages from input to output;
//   throughput is one beat per cycle while the receiver does not stall. The
//   quarter-wave sine table is constant logic with two read ports in one
//   stage.
//   Reset (rst, synchronous) empties the pipeline and loads the default
//   registers: value_inside 1.0, value_outside 0.0, alpha 1.0, inv_alpha 1.0.
//   When the receiver stalls, each stage holds its beat and bubbles ahead of
//   the stall still fill, so up to ten beats are taken before item_stall rises.
module smoothed_heaviside_property_blend #(
  parameter int unsigned SINE_TABLE_DEPTH = shpb_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               item_valid,
  output logic                               item_stall,
  input  shpb_pkg::item_t                    item_data,
  // output channel
  output logic                               res_valid,
  input  logic                               res_stall,
  output shpb_pkg::result_t                  res_data,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [shpb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam int unsigned SineEntries = SINE_TABLE_DEPTH + 1;
  localparam int unsigned IdxW        = $clog2(SineEntries);
  localparam int unsigned PosW        = 15 + IdxW;
  localparam int unsigned SinW        = shpb_pkg::SIN_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] value_inside;
  logic signed [31:0] value_outside;
  logic        [30:0] alpha;
  logic        [30:0] inv_alpha;
  logic signed [32:0] delta_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_inside  <= shpb_pkg::VALUE_INSIDE_RST;
      value_outside <= shpb_pkg::VALUE_OUTSIDE_RST;
      alpha         <= shpb_pkg::ALPHA_RST;
      inv_alpha     <= shpb_pkg::INV_ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        shpb_pkg::REG_VALUE_INSIDE:  value_inside  <= cfg_data;
        shpb_pkg::REG_VALUE_OUTSIDE: value_outside <= cfg_data;
        shpb_pkg::REG_ALPHA:         alpha         <= cfg_data[30:0];
        shpb_pkg::REG_INV_ALPHA:     inv_alpha     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // outside minus inside, registered from the configuration registers
  always_ff @(posedge clk) begin
    delta_value <= {value_outside[31], value_outside} - {value_inside[31], value_inside};
  end

  // ---------------------------------------------------------------------------
  // Quarter-wave sine table, built at elaboration
  // ---------------------------------------------------------------------------
  logic [SinW-1:0] sin_tab [SineEntries];

  for (genvar k = 0; k < SineEntries; k++) begin : g_sin
    // angle in Q30, sine by a ten-term Taylor series in Q30
    localparam longint unsigned Ang =
      (shpb_pkg::PI_Q30 * 64'(k)) / (64'd2 * 64'(SINE_TABLE_DEPTH));
    localparam longint unsigned Ang2  = (Ang * Ang) >> 30;
    localparam longint unsigned Term1 = ((Ang * Ang2) >> 30) / 64'd6;
    localparam longint unsigned Term2 = ((Term1 * Ang2) >> 30) / 64'd20;
    localparam longint unsigned Term3 = ((Term2 * Ang2) >> 30) / 64'd42;
    localparam longint unsigned Term4 = ((Term3 * Ang2) >> 30) / 64'd72;
    localparam longint unsigned Term5 = ((Term4 * Ang2) >> 30) / 64'd110;
    localparam longint unsigned Term6 = ((Term5 * Ang2) >> 30) / 64'd156;
    localparam longint unsigned Term7 = ((Term6 * Ang2) >> 30) / 64'd210;
    localparam longint unsigned Term8 = ((Term7 * Ang2) >> 30) / 64'd272;
    localparam longint unsigned Term9 = ((Term8 * Ang2) >> 30) / 64'd342;
    localparam longint SinSum =
      longint'(Ang) - longint'(Term1) + longint'(Term2) - longint'(Term3)
      + longint'(Term4) - longint'(Term5) + longint'(Term6) - longint'(Term7)
      + longint'(Term8) - longint'(Term9);
    localparam longint unsigned SinPos = (SinSum < 0) ? 64'd0 : $unsigned(SinSum);
    // scale by 65536/(2*pi), round to nearest
    localparam longint unsigned Entry =
      (SinPos * 64'd65536 + shpb_pkg::PI_Q30) / (64'd2 * shpb_pkg::PI_Q30);
    assign sin_tab[k] = Entry[SinW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage valids and ready chain
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9, rdy10;

  assign rdy10 = !v10 || !res_stall;
  assign rdy9  = !v9  || rdy10;
  assign rdy8  = !v8  || rdy9;
  assign rdy7  = !v7  || rdy8;
  assign rdy6  = !v6  || rdy7;
  assign rdy5  = !v5  || rdy6;
  assign rdy4  = !v4  || rdy5;
  assign rdy3  = !v3  || rdy4;
  assign rdy2  = !v2  || rdy3;
  assign rdy1  = !v1  || rdy2;

  assign item_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      if (rdy1)  v1  <= item_valid;
      if (rdy2)  v2  <= v1;
      if (rdy3)  v3  <= v2;
      if (rdy4)  v4  <= v3;
      if (rdy5)  v5  <= v4;
      if (rdy6)  v6  <= v5;
      if (rdy7)  v7  <= v6;
      if (rdy8)  v8  <= v7;
      if (rdy9)  v9  <= v8;
      if (rdy10) v10 <= v9;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: level-set value (side average is floor of the 33-bit sum)
  // ---------------------------------------------------------------------------
  logic signed [31:0] phi1;
  logic        [32:0] side_sum;

  assign side_sum = {item_data.level_a[31], item_data.level_a}
                  + {item_data.level_b[31], item_data.level_b};

  always_ff @(posedge clk) begin
    if (rdy1) begin
      phi1 <= item_data.action ? side_sum[32:1] : item_data.level_a;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: band test and magnitude
  // ---------------------------------------------------------------------------
  shpb_pkg::band_e    band2;
  logic               neg2;
  logic        [30:0] mag2;
  logic signed [32:0] phi_ext;
  logic signed [32:0] alpha_ext;
  logic        [31:0] mag_full;
  shpb_pkg::band_e    band_next;

  assign phi_ext   = {phi1[31], phi1};
  assign alpha_ext = {2'b00, alpha};
  assign mag_full  = phi1[31] ? (~phi1 + 32'd1) : phi1;

  always_comb begin
    priority if (phi_ext < -alpha_ext) begin
      band_next = shpb_pkg::BAND_LOW;
    end else if (phi_ext > alpha_ext) begin
      band_next = shpb_pkg::BAND_HIGH;
    end else begin
      band_next = shpb_pkg::BAND_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      band2 <= band_next;
      neg2  <= phi1[31];
      mag2  <= mag_full[30:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: |phi| * inv_alpha
  // ---------------------------------------------------------------------------
  shpb_pkg::band_e band3;
  logic            neg3;
  logic [61:0]     xprod3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      band3  <= band2;
      neg3   <= neg2;
      xprod3 <= 62'(mag2) * 62'(inv_alpha);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round to Q16 and clamp to 1.0
  // ---------------------------------------------------------------------------
  shpb_pkg::band_e band4;
  logic            neg4;
  logic [16:0]     xm4;
  logic [61:0]     xround;
  logic [45:0]     xr;

  assign xround = xprod3 + 62'd32768;
  assign xr     = xround[61:16];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      band4 <= band3;
      neg4  <= neg3;
      xm4   <= (xr > 46'(shpb_pkg::ONE_Q16)) ? shpb_pkg::ONE_Q16 : xr[16:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: fold to quarter wave, table position
  // ---------------------------------------------------------------------------
  shpb_pkg::band_e band5;
  logic            neg5;
  logic [16:0]     xm5;
  logic [IdxW-1:0] idx5;
  logic [14:0]     frac5;
  logic [16:0]     fold;
  logic [PosW-1:0] pos;

  assign fold = (xm4 <= shpb_pkg::HALF_Q16) ? xm4 : (shpb_pkg::ONE_Q16 - xm4);
  assign pos  = PosW'(PosW'(fold[15:0]) * PosW'(SINE_TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (rdy5) begin
      band5 <= band4;
      neg5  <= neg4;
      xm5   <= xm4;
      idx5  <= pos[PosW-1:15];
      frac5 <= pos[14:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: table read, two neighboring entries
  // ---------------------------------------------------------------------------
  shpb_pkg::band_e band6;
  logic            neg6;
  logic [16:0]     xm6;
  logic [14:0]     frac6;
  logic [SinW-1:0] tlo6;
  logic [SinW-1:0] tdiff6;
  logic            interp6;
  logic            last_entry;
  logic [IdxW-1:0] idx_hi;
  logic [SinW-1:0] t_lo;
  logic [SinW-1:0] t_hi;

  assign last_entry = (idx5 == IdxW'(SINE_TABLE_DEPTH));
  assign idx_hi     = last_entry ? idx5 : (idx5 + IdxW'(1));
  assign t_lo       = sin_tab[idx5];
  assign t_hi       = sin_tab[idx_hi];

  always_ff @(posedge clk) begin
    if (rdy6) begin
      band6   <= band5;
      neg6    <= neg5;
      xm6     <= xm5;
      frac6   <= frac5;
      tlo6    <= t_lo;
      tdiff6  <= t_hi - t_lo;
      interp6 <= !last_entry && (t_hi >= t_lo);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: interpolation product
  // ---------------------------------------------------------------------------
  shpb_pkg::band_e  band7;
  logic             neg7;
  logic [16:0]      xm7;
  logic [SinW-1:0]  tlo7;
  logic [SinW+14:0] lerp7;

  always_ff @(posedge clk) begin
    if (rdy7) begin
      band7 <= band6;
      neg7  <= neg6;
      xm7   <= xm6;
      tlo7  <= tlo6;
      lerp7 <= interp6 ? ((SinW + 15)'(tdiff6) * (SinW + 15)'(frac6)) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: sine term, weight
  // ---------------------------------------------------------------------------
  logic [16:0]      weight8;
  logic [SinW+14:0] lerp_rnd;
  logic [16:0]      sin_term;
  logic [16:0]      gsum;
  logic [16:0]      g;
  logic [16:0]      weight_next;

  assign lerp_rnd = lerp7 + (SinW + 15)'(16384);
  assign sin_term = 17'(tlo7) + 17'(lerp_rnd[SinW+14:15]);
  assign gsum     = {1'b0, xm7[16:1]} + sin_term;
  assign g        = (gsum > shpb_pkg::HALF_Q16) ? shpb_pkg::HALF_Q16 : gsum;

  always_comb begin
    unique case (band7)
      shpb_pkg::BAND_LOW:  weight_next = '0;
      shpb_pkg::BAND_HIGH: weight_next = shpb_pkg::ONE_Q16;
      shpb_pkg::BAND_MID:  weight_next = neg7 ? (shpb_pkg::HALF_Q16 - g)
                                              : (shpb_pkg::HALF_Q16 + g);
      default:             weight_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy8) begin
      weight8 <= weight_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: blend product (outside - inside) * weight
  // ---------------------------------------------------------------------------
  logic        [16:0] weight9;
  logic signed [50:0] bprod9;

  always_ff @(posedge clk) begin
    if (rdy9) begin
      weight9 <= weight8;
      bprod9  <= 51'(delta_value) * $signed({1'b0, weight8});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: round, add inside value, saturate
  // ---------------------------------------------------------------------------
  logic signed [50:0] bround;
  logic signed [34:0] q;
  logic signed [34:0] sum_res;
  logic signed [31:0] res_sat;

  assign bround  = bprod9 + 51'sd32768;
  assign q       = 35'(bround >>> 16);
  assign sum_res = 35'(value_inside) + q;

  always_comb begin
    priority if (sum_res > 35'sd2147483647) begin
      res_sat = 32'sh7FFFFFFF;
    end else if (sum_res < -35'sd2147483648) begin
      res_sat = 32'sh80000000;
    end else begin
      res_sat = sum_res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy10) begin
      res_data.weight       <= weight9;
      res_data.property_res <= res_sat;
    end
  end

  assign res_valid = v10;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an open output stage means every stage can move
  a_no_stall_when_out_free: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || !res_stall) |-> !item_stall)
    else $error("input stalled while output stage is free");

  // weights never pass 1.0
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.weight <= shpb_pkg::ONE_Q16))
    else $error("weight above 1.0");

  // table index stays inside the table
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (idx5 <= IdxW'(SINE_TABLE_DEPTH)))
    else $error("sine table index out of range");

  // inside the band the magnitude never exceeds alpha
  a_band_mag: assert property (@(posedge clk) disable iff (rst)
    (v2 && band2 == shpb_pkg::BAND_MID) |-> (mag2 <= alpha))
    else $error("band magnitude above alpha");

endmodule
